>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define EFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition never holds
`define EFD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

>>> rtl/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package efd_pkg;

	localparam int MAX_CHANNELS_DEF = 32;
	localparam int AUX_BYTES        = 7;
	localparam int Q_DEPTH          = 2;
	localparam int TDATA_W          = 120;

	localparam logic [7:0] HDR_BYTE  = 8'hA0;
	localparam logic [7:0] FTR_BYTE  = 8'hC0;
	localparam logic [5:0] CFG_RESET = 6'd8;

	// result kinds carried on tuser
	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_FRAME   = 2'd1,
		KIND_BATTERY = 2'd2,
		KIND_DROP    = 2'd3
	} kind_t;

	// one finished frame handed from the parser to the emitter
	typedef struct packed {
		logic        drop;
		logic        bank;
		logic [5:0]  n;
		logic [7:0]  sn;
		logic [31:0] ms;
		logic [9:0]  us;
		logic [3:0]  mk;
		logic        t1;
		logic        t2;
		logic        batt;
		logic [4:0]  bnum;
		logic [31:0] bms;
		logic [9:0]  bus;
		logic [3:0]  bmk;
		logic [15:0] temp;
		logic [15:0] volt;
	} job_t;

	// one result item
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         sn;
		logic [4:0]         ch;
		logic signed [23:0] value;
		logic [31:0]        ms;
		logic [9:0]         us;
		logic [3:0]         mk;
		logic               t1;
		logic               t2;
		logic [15:0]        temp;
		logic [15:0]        volt;
		logic               last;
	} res_t;

endpackage

>>> rtl/eeg_frame_deframer.sv
// Each job passes the job queue, then the output stage register. Throughput: one
// byte per cycle in, one result item per cycle out while m_axis_tready is high; the
// parser stalls only while two finished frames wait in the job queue (two memory
// banks). A good frame of 3n+10 bytes yields n+1 or n+2 items; the stream keeps
// its rate. Reset: hunting for a header, queue empty, battery state zero, channel
// count 8; the sample memory and auxiliary bytes are undefined until written.
// ----------------------------------------------------------------------------
// eeg_frame_deframer
// Serial packet deframer for 24-bit biosignal frames with battery records.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eeg_frame_deframer import efd_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,      // num_channels
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // data_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// sample_number, channel_index, sample_value, timestamp_ms, timestamp_us,
	// marker, trigger_one, trigger_two, temperature, battery_mv, zero pad
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]         m_axis_tuser,   // kind
	output logic               m_axis_tlast    // last
);

	localparam int         CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam logic [5:0] MAX_N = 6'(MAX_CHANNELS);

	logic [5:0]   num_ch_q;
	logic [5:0]   n_eff;
	logic         take;
	logic         push;
	job_t         push_job;
	logic         pop;
	logic         head_valid;
	job_t         head;
	logic [1:0]   q_count;
	logic         wr_en;
	logic [CH_AW:0] wr_addr;
	logic [23:0]  wr_data;
	res_t         res;

	// hold the channel count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q <= CFG_RESET;
		end else if (cfg_we) begin
			num_ch_q <= cfg_wdata;
		end
	end

	// clamp the channel count to its working range
	always_comb begin
		if (num_ch_q == 6'd0) begin
			n_eff = 6'd1;
		end else if (num_ch_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = num_ch_q;
		end
	end

	// take bytes while a job slot is free
	assign s_axis_tready = q_count < 2'(Q_DEPTH);
	assign take          = s_axis_tvalid && s_axis_tready;

	efd_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_axis_tdata),
		.n_eff     (n_eff),
		.push      (push),
		.push_job  (push_job),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	efd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	efd_back #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	// pack the result item
	assign m_axis_tdata = {3'b000, res.volt, res.temp, res.t2, res.t1, res.mk,
		res.us, res.ms, res.value, res.ch, res.sn};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

	// checks
	`EFD_ASSERT_NEVER(a_queue_bound, clk, arst_n, q_count > 2'(Q_DEPTH), "job queue overrun")
	`EFD_ASSERT_IMPLY(a_drop_last, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_DROP, m_axis_tlast, "drop record not last")
	`EFD_ASSERT_NEVER(a_sample_not_last, clk, arst_n, m_axis_tvalid && m_axis_tlast && m_axis_tuser == KIND_SAMPLE, "channel item marked last")
	`EFD_ASSERT_IMPLY(a_batt_number, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_BATTERY, m_axis_tdata[7:5] == 3'b000, "battery number out of range")

endmodule

>>> rtl/efd_front.sv
// ----------------------------------------------------------------------------
// efd_front
// Byte parser: hunts the header, gathers the frame body, writes channel
// samples into the sample memory and hands a job to the queue at the footer.
// ----------------------------------------------------------------------------
module efd_front import efd_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      take,
	input  logic [7:0]                                data_byte,
	input  logic [5:0]                                n_eff,
	output logic                                      push,
	output job_t                                      push_job,
	output logic                                      wr_en,
	output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] wr_addr,
	output logic [23:0]                               wr_data
);

	localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	typedef enum logic [1:0] {
		ST_HUNT = 2'b01,
		ST_BODY = 2'b10
	} state_t;

	state_t      state_q;
	logic [6:0]  pos_q;
	logic [1:0]  ph_q;
	logic [5:0]  ch_q;
	logic [7:0]  sn_q;
	logic [15:0] part_q;
	logic        bank_q;
	logic [7:0]  aux_q [AUX_BYTES];
	logic [4:0]  bnum_q;
	logic [31:0] bms_q;
	logic [9:0]  bus_q;
	logic [3:0]  bmk_q;
	logic [15:0] temp_q;
	logic [15:0] volt_q;

	logic [6:0]  three_n;
	logic [6:0]  lim;
	logic [6:0]  aux_off;
	logic        in_body;
	logic        in_chan;
	logic        in_aux;
	logic        body_take;
	logic        good;
	logic [31:0] ms;
	logic [9:0]  us;

	// classify the current byte position against the channel count
	always_comb begin
		three_n   = {n_eff, 1'b0} + {1'b0, n_eff};
		lim       = three_n + 7'd8;
		aux_off   = pos_q - three_n - 7'd1;
		in_body   = pos_q < lim;
		in_chan   = (pos_q != 7'd0) && (pos_q <= three_n);
		in_aux    = (pos_q != 7'd0) && !in_chan && (aux_off < 7'(AUX_BYTES));
		body_take = take && (state_q == ST_BODY);
		push      = body_take && !in_body;
		good      = data_byte == FTR_BYTE;
	end

	// write a channel sample on its third byte
	assign wr_en   = body_take && in_body && in_chan && (ph_q == 2'd2);
	assign wr_addr = {bank_q, ch_q[CH_AW-1:0]};
	assign wr_data = {part_q, data_byte};

	// build the job from the auxiliary bytes and battery state
	always_comb begin
		ms = {aux_q[3], aux_q[4], aux_q[5], aux_q[6]};
		us = {aux_q[1][1:0], aux_q[2]};
		push_job.drop = !good;
		push_job.bank = bank_q;
		push_job.n    = n_eff;
		push_job.sn   = sn_q;
		push_job.ms   = ms;
		push_job.us   = us;
		push_job.mk   = aux_q[1][7:4];
		push_job.t1   = aux_q[1][2];
		push_job.t2   = aux_q[1][3];
		push_job.batt = sn_q[2:0] == 3'd3;
		push_job.bnum = bnum_q;
		push_job.bms  = bms_q;
		push_job.bus  = bus_q;
		push_job.bmk  = bmk_q;
		push_job.temp = temp_q;
		push_job.volt = volt_q + {8'h00, aux_q[0]};
	end

	// hold auxiliary bytes
	always_ff @(posedge clk) begin
		if (body_take && in_body && in_aux) begin
			aux_q[aux_off[2:0]] <= data_byte;
		end
	end

	// advance the frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			pos_q   <= 7'd0;
			ph_q    <= 2'd0;
			ch_q    <= 6'd0;
			sn_q    <= 8'd0;
			part_q  <= 16'd0;
			bank_q  <= 1'b0;
		end else if (take) begin
			unique case (state_q)
				ST_HUNT: begin
					if (data_byte == HDR_BYTE) begin
						state_q <= ST_BODY;
						pos_q   <= 7'd0;
						ph_q    <= 2'd0;
						ch_q    <= 6'd0;
					end
				end
				ST_BODY: begin
					if (in_body) begin
						pos_q <= pos_q + 7'd1;
						if (pos_q == 7'd0) begin
							sn_q <= data_byte;
						end else begin
							if (ph_q == 2'd2) begin
								ph_q <= 2'd0;
								ch_q <= ch_q + 6'd1;
							end else begin
								ph_q <= ph_q + 2'd1;
							end
							if (in_chan && ph_q == 2'd0) begin
								part_q <= {data_byte, 8'h00};
							end else if (in_chan && ph_q == 2'd1) begin
								part_q[7:0] <= data_byte;
							end
						end
					end else begin
						state_q <= ST_HUNT;
						pos_q   <= 7'd0;
						if (good) begin
							bank_q <= !bank_q;
						end
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

	// update battery state after a good frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnum_q <= 5'd0;
			bms_q  <= 32'd0;
			bus_q  <= 10'd0;
			bmk_q  <= 4'd0;
			temp_q <= 16'd0;
			volt_q <= 16'd0;
		end else if (push && good) begin
			unique case (sn_q[2:0])
				3'd0: begin
					bnum_q <= sn_q[7:3];
					bms_q  <= ms;
					bus_q  <= us;
					bmk_q  <= aux_q[1][7:4];
					temp_q <= {aux_q[0], 8'h00};
					volt_q <= 16'd0;
				end
				3'd1: temp_q <= temp_q + {8'h00, aux_q[0]};
				3'd2: volt_q <= {aux_q[0], 8'h00};
				3'd3: volt_q <= push_job.volt;
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/efd_queue.sv
// ----------------------------------------------------------------------------
// efd_queue
// Two-entry job queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module efd_queue import efd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       push_job,
	input  logic       pop,
	output logic       head_valid,
	output job_t       head,
	output logic [1:0] count
);

	job_t       entry_q [Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head_valid = count_q != 2'd0;
	assign head       = entry_q[rd_ptr_q];
	assign count      = count_q;

	// store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/efd_back.sv
// ----------------------------------------------------------------------------
// efd_back
// Result emitter: holds the two-bank sample memory and walks the head job,
// one item per cycle while res_ready is high, into a registered output stage.
// ----------------------------------------------------------------------------
module efd_back import efd_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      wr_en,
	input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] wr_addr,
	input  logic [23:0]                               wr_data,
	input  logic                                      head_valid,
	input  job_t                                      head,
	output logic                                      pop,
	output logic                                      res_valid,
	input  logic                                      res_ready,
	output res_t                                      res
);

	localparam int CH_AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int MEM_DEPTH = 2 ** (CH_AW + 1);

	logic [23:0] mem [MEM_DEPTH];

	logic [5:0]  idx_q;
	logic        valid_s2;
	logic [23:0] rdata_s2;
	kind_t       kind_s2;
	logic [7:0]  sn_s2;
	logic [4:0]  ch_s2;
	logic [31:0] ms_s2;
	logic [9:0]  us_s2;
	logic [3:0]  mk_s2;
	logic        t1_s2;
	logic        t2_s2;
	logic [15:0] temp_s2;
	logic [15:0] volt_s2;
	logic        last_s2;

	kind_t       it_kind;
	logic        it_last;
	logic        advance;
	logic [CH_AW:0] rd_addr;

	// decode the item at the current index of the head job
	always_comb begin
		if (head.drop) begin
			it_kind = KIND_DROP;
			it_last = 1'b1;
		end else if (idx_q < head.n) begin
			it_kind = KIND_SAMPLE;
			it_last = 1'b0;
		end else if (idx_q == head.n) begin
			it_kind = KIND_FRAME;
			it_last = !head.batt;
		end else begin
			it_kind = KIND_BATTERY;
			it_last = 1'b1;
		end
		advance = head_valid && (!valid_s2 || res_ready);
		pop     = advance && it_last;
		rd_addr = {head.bank, idx_q[CH_AW-1:0]};
	end

	// write samples, read the next one as the item moves out
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (advance) begin
			rdata_s2 <= mem[rd_addr];
		end
	end

	// step through the job and hold the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 6'd0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				idx_q    <= it_last ? 6'd0 : idx_q + 6'd1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// capture the item fields, zero where the kind does not use them
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s2 <= it_kind;
			last_s2 <= it_last;
			sn_s2   <= (it_kind == KIND_BATTERY) ? {3'b000, head.bnum} : head.sn;
			ch_s2   <= (it_kind == KIND_SAMPLE) ? idx_q[4:0] : 5'd0;
			if (it_kind == KIND_FRAME) begin
				ms_s2   <= head.ms;
				us_s2   <= head.us;
				mk_s2   <= head.mk;
				t1_s2   <= head.t1;
				t2_s2   <= head.t2;
				temp_s2 <= 16'd0;
				volt_s2 <= 16'd0;
			end else if (it_kind == KIND_BATTERY) begin
				ms_s2   <= head.bms;
				us_s2   <= head.bus;
				mk_s2   <= head.bmk;
				t1_s2   <= 1'b0;
				t2_s2   <= 1'b0;
				temp_s2 <= head.temp;
				volt_s2 <= head.volt;
			end else begin
				ms_s2   <= 32'd0;
				us_s2   <= 10'd0;
				mk_s2   <= 4'd0;
				t1_s2   <= 1'b0;
				t2_s2   <= 1'b0;
				temp_s2 <= 16'd0;
				volt_s2 <= 16'd0;
			end
		end
	end

	// drive the result
	always_comb begin
		res_valid  = valid_s2;
		res.kind   = kind_s2;
		res.sn     = sn_s2;
		res.ch     = ch_s2;
		res.value  = (kind_s2 == KIND_SAMPLE) ? rdata_s2 : 24'd0;
		res.ms     = ms_s2;
		res.us     = us_s2;
		res.mk     = mk_s2;
		res.t1     = t1_s2;
		res.t2     = t2_s2;
		res.temp   = temp_s2;
		res.volt   = volt_s2;
		res.last   = last_s2;
	end

endmodule
